### hdl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and helper functions for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 32;
    localparam int unsigned LOW_W  = 6;

    localparam logic [BYTE_W-1:0] CONT_MASK = 8'b1100_0000;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'b1000_0000;
    localparam logic [BYTE_W-1:0] LOW6_MASK = 8'b0011_1111;

    // One result transaction
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            string_end;
        logic            orphan_error;
    } utf8d_result_t;

    function automatic logic is_cont(input logic [BYTE_W-1:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    // Clear the run of leading one bits of a lead byte
    function automatic logic [BYTE_W-1:0] strip_lead(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        logic              run;
        r   = b;
        run = 1'b1;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (run && b[i]) begin
                r[i] = 1'b0;
            end else begin
                run = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/utf8d_core.sv
// ----------------------------------------------------------------------------
// utf8d_core
// Input register and per-byte decode: holds the pending code point and
// produces at most one result per cycle toward the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [utf8d_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                         in_last,
    input  wire logic                         res_ready,
    output logic                              res_push,
    output utf8d_pkg::utf8d_result_t          res_data
);

    logic                         in_valid_reg, in_valid_next;
    logic [utf8d_pkg::BYTE_W-1:0] in_byte_reg;
    logic                         in_last_reg;

    logic [utf8d_pkg::CP_W-1:0]   acc_reg, acc_next;
    logic                         pend_reg, pend_next;
    // second result of a lead byte that both ends the string and closes a code point
    logic                         flush_reg, flush_next;
    logic [utf8d_pkg::CP_W-1:0]   flush_cp_reg, flush_cp_next;

    logic                         consume;
    logic                         cont;
    logic [utf8d_pkg::CP_W-1:0]   lead_cp;
    logic [utf8d_pkg::CP_W-1:0]   cont_cp;

    assign consume  = in_valid_reg && res_ready && !flush_reg;
    assign in_ready = !in_valid_reg || consume;

    assign cont    = utf8d_pkg::is_cont(in_byte_reg);
    assign lead_cp = {{(utf8d_pkg::CP_W - utf8d_pkg::BYTE_W){1'b0}},
                      utf8d_pkg::strip_lead(in_byte_reg)};
    assign cont_cp = {acc_reg[utf8d_pkg::CP_W-utf8d_pkg::LOW_W-1:0],
                      in_byte_reg[utf8d_pkg::LOW_W-1:0]};

    always_comb begin
        in_valid_next = in_valid_reg;
        acc_next      = acc_reg;
        pend_next     = pend_reg;
        flush_next    = flush_reg;
        flush_cp_next = flush_cp_reg;
        res_push      = 1'b0;
        res_data      = '0;

        if (in_valid && in_ready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end

        if (flush_reg && res_ready) begin
            res_push                = 1'b1;
            res_data.code_point     = flush_cp_reg;
            res_data.string_end     = 1'b1;
            flush_next              = 1'b0;
        end else if (consume) begin
            if (cont) begin
                if (pend_reg) begin
                    acc_next = cont_cp;
                    if (in_last_reg) begin
                        res_push            = 1'b1;
                        res_data.code_point = cont_cp;
                        res_data.string_end = 1'b1;
                    end
                end else if (in_last_reg) begin
                    res_push              = 1'b1;
                    res_data.string_end   = 1'b1;
                    res_data.orphan_error = 1'b1;
                end
            end else begin
                acc_next  = lead_cp;
                pend_next = 1'b1;
                if (pend_reg) begin
                    res_push            = 1'b1;
                    res_data.code_point = acc_reg;
                    // owe the new code point as a second result, sent from flush_reg
                    if (in_last_reg) begin
                        flush_next    = 1'b1;
                        flush_cp_next = lead_cp;
                    end
                end else if (in_last_reg) begin
                    res_push            = 1'b1;
                    res_data.code_point = lead_cp;
                    res_data.string_end = 1'b1;
                end
            end
            if (in_last_reg) begin
                acc_next  = '0;
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            acc_reg      <= '0;
            pend_reg     <= 1'b0;
            flush_reg    <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            acc_reg      <= acc_next;
            pend_reg     <= pend_next;
            flush_reg    <= flush_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
        flush_cp_reg <= flush_cp_next;
    end

endmodule

`default_nettype wire

### hdl/utf8d_out_buf.sv
// ----------------------------------------------------------------------------
// utf8d_out_buf
// Result register with a skid stage, so the core can hand over one more
// result after the downstream side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_out_buf (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     push,
    input  wire utf8d_pkg::utf8d_result_t push_data,
    output logic                          push_ready,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output utf8d_pkg::utf8d_result_t      out_data
);

    logic                     main_valid_reg, main_valid_next;
    logic                     skid_valid_reg, skid_valid_next;
    utf8d_pkg::utf8d_result_t main_reg, main_next;
    utf8d_pkg::utf8d_result_t skid_reg, skid_next;
    logic                     pop;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;
    assign pop        = main_valid_reg && out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            // drain the skid entry first
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

### hdl/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Streaming UTF-8 byte to code point decoder.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per cycle on the s_ side unless m_tready holds it back
// (tlast marks the final byte of a string) and returns code points on the m_
// side, each closed when the next lead byte arrives or the string ends; tlast
// marks the string's last result and tuser flags a final continuation byte
// that had no lead byte (code point 0). The other exception to that rate is a
// lead byte that ends a string while a code point is open: it yields two
// results and holds the input until the second is sent, as the result register
// takes one transaction per cycle. Data passes an input and then a result register.
`default_nettype none

module utf8_stream_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] code_point
    output logic             m_tlast,   // string_end
    output logic             m_tuser    // [0] orphan_error
);

    logic                     res_ready;
    logic                     res_push;
    utf8d_pkg::utf8d_result_t res_data;
    utf8d_pkg::utf8d_result_t out_data;

    utf8d_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_ready (res_ready),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    utf8d_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_push),
        .push_data  (res_data),
        .push_ready (res_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tdata = out_data.code_point;
    assign m_tlast = out_data.string_end;
    assign m_tuser = out_data.orphan_error;

endmodule

`default_nettype wire

### hdl/utf8d_checker.sv
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    // an orphan result carries a zero code point and closes the string
    a_orphan_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 32'd0 && m_tlast)
        else $error("orphan result with nonzero code point or no tlast");

    // no result right after reset
    a_no_spurious: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result transaction right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    // input is taken while the result side is idle and nothing is owed
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && $past(!m_tvalid) && $past(!s_tvalid) && $past(aresetn)
            |-> s_tready)
        else $error("input stalled with an idle output");

endmodule

bind utf8_stream_decoder_unit utf8d_checker u_utf8d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/sv/tb_utf8_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_unit
// Self-checking bench for the streaming UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
// Feeds directed byte strings (extreme bytes, multi-byte characters, orphan
// continuations, two results from one byte, 32-bit wraparound), then random
// strings made mostly of well-formed UTF-8 characters with some noise. A
// scoreboard decodes every accepted byte on its own and compares each result
// transaction field by field, in order. Both sides of the stream idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------

module tb_utf8_stream_decoder_unit;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASE_BYTES = 550;

    // ------------------------------------------------------------------------
    // Scoreboard: decodes accepted bytes and holds the code points still due
    // ------------------------------------------------------------------------
    class utf8_code_point_board;
        logic [31:0]              cp_acc;
        bit                       cp_open;
        utf8d_pkg::utf8d_result_t due_q[$];
        int unsigned              errors;

        function new();
            cp_acc  = '0;
            cp_open = 1'b0;
            errors  = 0;
        endfunction

        function logic [7:0] clear_lead_ones(input logic [7:0] b);
            logic [7:0] v;
            int         i;
            v = b;
            i = 7;
            while (i >= 0 && v[i]) begin
                v[i] = 1'b0;
                i--;
            end
            return v;
        endfunction

        function void push_due(input logic [31:0] cp, input logic se, input logic oe);
            utf8d_pkg::utf8d_result_t r;
            r.code_point   = cp;
            r.string_end   = se;
            r.orphan_error = oe;
            due_q.push_back(r);
        endfunction

        function void note_byte(input logic [7:0] b, input logic last);
            if ((b & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_TAG) begin
                if (cp_open) begin
                    cp_acc = {cp_acc[25:0], b[5:0]};
                    if (last) push_due(cp_acc, 1'b1, 1'b0);
                end else if (last) begin
                    push_due('0, 1'b1, 1'b1);
                end
            end else begin
                // close the open code point before starting the new one
                if (cp_open) push_due(cp_acc, 1'b0, 1'b0);
                cp_acc  = {24'b0, clear_lead_ones(b)};
                cp_open = 1'b1;
                if (last) push_due(cp_acc, 1'b1, 1'b0);
            end
            if (last) begin
                cp_acc  = '0;
                cp_open = 1'b0;
            end
        endfunction

        function void check_code_point(input logic [31:0] cp, input logic se,
                                       input logic oe);
            utf8d_pkg::utf8d_result_t want;
            if (due_q.size() == 0) begin
                $error("unexpected result: code_point %h string_end %b orphan_error %b",
                       cp, se, oe);
                errors++;
            end else begin
                want = due_q.pop_front();
                if (cp !== want.code_point) begin
                    $error("code_point: expected %h, actual %h", want.code_point, cp);
                    errors++;
                end
                if (se !== want.string_end) begin
                    $error("string_end: expected %b, actual %b", want.string_end, se);
                    errors++;
                end
                if (oe !== want.orphan_error) begin
                    $error("orphan_error: expected %b, actual %b", want.orphan_error, oe);
                    errors++;
                end
            end
        endfunction

        function int unsigned outstanding();
            return due_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    utf8_code_point_board board;
    logic [7:0]           text_q[$];
    int unsigned          snd_idle;
    int unsigned          rcv_idle;
    int unsigned          bytes_sent;
    int unsigned          cycle_cnt;
    bit                   hold_armed;

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    utf8_stream_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    task automatic drive_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        board.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            drive_byte(text_q[i], i == text_q.size() - 1);
        end
    endtask

    task automatic send_bytes(input logic [7:0] b0, input logic [7:0] b1 = 8'h00,
                              input int unsigned n = 1);
        text_q.delete();
        text_q.push_back(b0);
        if (n > 1) text_q.push_back(b1);
        send_text();
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    // Append one character, mostly well-formed, sometimes noise
    function automatic void add_char();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: begin
                text_q.push_back({1'b0, 7'($urandom)});
            end
            2, 3: begin
                text_q.push_back({3'b110, 5'($urandom)});
                text_q.push_back(cont_byte());
            end
            4: begin
                text_q.push_back({4'b1110, 4'($urandom)});
                repeat (2) text_q.push_back(cont_byte());
            end
            5: begin
                text_q.push_back({5'b11110, 3'($urandom)});
                repeat (3) text_q.push_back(cont_byte());
            end
            6: begin
                // any lead byte with a long tail: exercises the 32-bit wrap
                text_q.push_back({2'b11, 6'($urandom)});
                n = $urandom_range(0, 8);
                repeat (n) text_q.push_back(cont_byte());
            end
            7: begin
                text_q.push_back(8'($urandom));
            end
            8: begin
                n = $urandom_range(1, 3);
                repeat (n) text_q.push_back(cont_byte());
            end
            default: begin
                text_q.push_back($urandom_range(0, 1) ? 8'hFF : 8'hFE);
                n = $urandom_range(0, 6);
                repeat (n) text_q.push_back(cont_byte());
            end
        endcase
    endfunction

    task automatic send_random_string();
        int unsigned nchars;
        text_q.delete();
        if ($urandom_range(0, 19) == 0) begin
            // lone continuation: orphan at the end of the string
            text_q.push_back(cont_byte());
        end else begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 2)) text_q.push_back(cont_byte());
            end
            nchars = $urandom_range(1, 6);
            repeat (nchars) add_char();
        end
        send_text();
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random ready, one long hold-off once armed
    // ------------------------------------------------------------------------
    initial begin
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_armed && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rcv_idle);
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_code_point(m_tdata, m_tlast, m_tuser);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_utf8_stream_decoder_unit: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned target;
        board        = new();
        snd_idle     = 16;
        rcv_idle     = 86;
        bytes_sent   = 0;
        hold_armed   = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extreme bytes as one-byte strings; 0xFF and 0xFE strip to zero
        send_bytes(8'h00);
        send_bytes(8'h7F);
        send_bytes(8'hFF);
        send_bytes(8'hFE);
        // two, three and four byte characters
        send_bytes(8'hC3, 8'hA9, 2);
        text_q = '{8'hE2, 8'h82, 8'hAC};
        send_text();
        text_q = '{8'hF0, 8'h9F, 8'h98, 8'h80};
        send_text();
        // orphan continuation dropped, then an orphan at the end
        send_bytes(8'h80, 8'h41, 2);
        send_bytes(8'hBF);
        // lead byte that ends the string while one is open: two results
        send_bytes(8'h41, 8'h42, 2);
        // long tail shifts past 32 bits
        text_q = '{8'hC1, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
        send_text();

        target = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target) send_random_string();

        snd_idle = 86;
        rcv_idle = 16;
        target = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target) send_random_string();

        // no idling; the receiver stalls once so the input backs up
        snd_idle   = 0;
        rcv_idle   = 0;
        hold_armed = 1'b1;
        target = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target) send_random_string();
        s_tvalid <= 1'b0;

        while (board.outstanding() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (board.errors == 0) begin
            $display("tb_utf8_stream_decoder_unit: done, clean");
        end else begin
            $display("tb_utf8_stream_decoder_unit: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
hdl/utf8d_pkg.sv
hdl/utf8d_core.sv
hdl/utf8d_out_buf.sv
hdl/utf8_stream_decoder_unit.sv
hdl/utf8d_checker.sv
tb/sv/tb_utf8_stream_decoder_unit.sv
